// ===== hw/rtl/lsit_pkg.sv =====
// Shared constants for the line and sphere intersection test pipeline.
package lsit_pkg;

  // Number of coordinate axes in every vector.
  localparam int unsigned NumAxes = 3;

  // Axis that follows and axis that precedes each axis, used by the cross product.
  localparam int unsigned NextAxis [NumAxes] = '{1, 2, 0};
  localparam int unsigned PrevAxis [NumAxes] = '{2, 0, 1};

endpackage

// ===== hw/rtl/line_sphere_intersect_test_top.sv =====
// Throughput: one test per cycle; busy_o is always low and a beat may enter every cycle.
// The latency is set by the restoring divider, one quotient bit per stage, COORD_BITS + 2 deep.
// Reset clears the valid bits of all stages, so no strobe appears until a test is started.
// The receiver cannot stall; each result is shown on done_o for exactly one cycle.
module line_sphere_intersect_test_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] end_z_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic signed [COORD_BITS-1:0] center_z_i,
  input  logic        [COORD_BITS-2:0] radius_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] near_x_o,
  output logic signed [COORD_BITS-1:0] near_y_o,
  output logic signed [COORD_BITS-1:0] near_z_o
);
  import lsit_pkg::*;

  localparam int unsigned N    = COORD_BITS;
  localparam int unsigned LW   = N + 1;        // difference vectors, signed
  localparam int unsigned PW   = 2 * N + 2;    // single products, signed
  localparam int unsigned CW   = 2 * N + 3;    // dot and cross sums, signed
  localparam int unsigned LLW  = 2 * N + 2;    // squared lengths, unsigned
  localparam int unsigned MW   = 2 * N + 2;    // magnitudes of dot and cross terms
  localparam int unsigned HW   = MW / 2;       // low half of a split operand
  localparam int unsigned RRW  = 2 * N - 2;    // squared radius
  localparam int unsigned RLW  = RRW + LLW;    // squared radius times squared length
  localparam int unsigned N2W  = 2 * MW + 2;   // squared cross product length
  localparam int unsigned NUMW = N + MW;       // axis offset numerator
  localparam int unsigned XW   = NUMW + 2;     // rounded dividend
  localparam int unsigned DW   = LLW + 1;      // divisor, twice the squared length
  localparam int unsigned QB   = N + 2;        // quotient bits, one per divider stage
  localparam int unsigned SW   = N + 4;        // point sum before saturation

  localparam logic signed [SW-1:0] SatHi = SW'((2 ** (N - 1)) - 1);
  localparam logic signed [SW-1:0] SatLo = -SatHi - SW'(1);

  // The pipeline never holds off a new beat.
  assign busy_o = 1'b0;

  logic signed [N-1:0] in_s [NumAxes];
  logic signed [N-1:0] in_e [NumAxes];
  logic signed [N-1:0] in_c [NumAxes];

  assign in_s = '{start_x_i, start_y_i, start_z_i};
  assign in_e = '{end_x_i, end_y_i, end_z_i};
  assign in_c = '{center_x_i, center_y_i, center_z_i};

  // Stage 1: line direction and center offset.
  logic                 v1_q;
  logic signed [N-1:0]  s1_q [NumAxes];
  logic signed [LW-1:0] l1_q [NumAxes];
  logic signed [LW-1:0] t1_q [NumAxes];
  logic [N-2:0]         r1_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumAxes; i++) begin
      s1_q[i] <= in_s[i];
      l1_q[i] <= LW'(in_e[i]) - LW'(in_s[i]);
      t1_q[i] <= LW'(in_c[i]) - LW'(in_s[i]);
    end
    r1_q <= radius_i;
  end

  // Stage 2: products of the two vectors for the dot, length and cross terms, and the squared radius.
  logic                 v2_q;
  logic signed [N-1:0]  s2_q [NumAxes];
  logic signed [LW-1:0] l2_q [NumAxes];
  logic signed [PW-1:0] pll_q [NumAxes];
  logic signed [PW-1:0] ptt_q [NumAxes];
  logic signed [PW-1:0] pd_q [NumAxes];
  logic signed [PW-1:0] pa_q [NumAxes];
  logic signed [PW-1:0] pb_q [NumAxes];
  logic [RRW-1:0]       rr2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumAxes; i++) begin
      s2_q[i]  <= s1_q[i];
      l2_q[i]  <= l1_q[i];
      pll_q[i] <= PW'(l1_q[i]) * PW'(l1_q[i]);
      ptt_q[i] <= PW'(t1_q[i]) * PW'(t1_q[i]);
      pd_q[i]  <= PW'(l1_q[i]) * PW'(t1_q[i]);
      pa_q[i]  <= PW'(l1_q[NextAxis[i]]) * PW'(t1_q[PrevAxis[i]]);
      pb_q[i]  <= PW'(l1_q[PrevAxis[i]]) * PW'(t1_q[NextAxis[i]]);
    end
    rr2_q <= RRW'(r1_q) * RRW'(r1_q);
  end

  // Stage 3: dot product, squared lengths and cross product.
  logic                  v3_q;
  logic signed [N-1:0]   s3_q [NumAxes];
  logic signed [LW-1:0]  l3_q [NumAxes];
  logic signed [CW-1:0]  d3_q;
  logic signed [CW-1:0]  cr3_q [NumAxes];
  logic [LLW-1:0]        ll3_q;
  logic [LLW-1:0]        tl3_q;
  logic [RRW-1:0]        rr3_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumAxes; i++) begin
      s3_q[i]  <= s2_q[i];
      l3_q[i]  <= l2_q[i];
      cr3_q[i] <= CW'(pa_q[i]) - CW'(pb_q[i]);
    end
    d3_q  <= CW'(pd_q[0]) + CW'(pd_q[1]) + CW'(pd_q[2]);
    ll3_q <= LLW'(unsigned'(pll_q[0])) + LLW'(unsigned'(pll_q[1]))
           + LLW'(unsigned'(pll_q[2]));
    tl3_q <= LLW'(unsigned'(ptt_q[0])) + LLW'(unsigned'(ptt_q[1]))
           + LLW'(unsigned'(ptt_q[2]));
    rr3_q <= rr2_q;
  end

  // Magnitudes feeding the split multipliers.
  logic [MW-1:0] cr_mag [NumAxes];
  logic [N-1:0]  l_mag [NumAxes];
  logic [MW-1:0] d_mag;

  always_comb begin
    d_mag = d3_q[CW-1] ? MW'(unsigned'(-d3_q)) : MW'(unsigned'(d3_q));
    for (int i = 0; i < NumAxes; i++) begin
      cr_mag[i] = cr3_q[i][CW-1] ? MW'(unsigned'(-cr3_q[i])) : MW'(unsigned'(cr3_q[i]));
      l_mag[i]  = l3_q[i][LW-1] ? N'(unsigned'(-l3_q[i])) : N'(unsigned'(l3_q[i]));
    end
  end

  // Stage 4: partial products over the low and high halves of each wide operand.
  logic                     v4_q;
  logic signed [N-1:0]      s4_q [NumAxes];
  logic [NumAxes-1:0]       neg4_q;
  logic [MW+HW-1:0]         crl4_q [NumAxes];
  logic [MW+HW-1:0]         crh4_q [NumAxes];
  logic [RRW+HW-1:0]        rll4_q;
  logic [RRW+HW-1:0]        rlh4_q;
  logic [N+HW-1:0]          nl4_q [NumAxes];
  logic [N+HW-1:0]          nh4_q [NumAxes];
  logic [LLW-1:0]           ll4_q;
  logic [LLW-1:0]           tl4_q;
  logic [RRW-1:0]           rr4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumAxes; i++) begin
      s4_q[i]   <= s3_q[i];
      neg4_q[i] <= l3_q[i][LW-1] ^ d3_q[CW-1];
      crl4_q[i] <= (MW+HW)'(cr_mag[i]) * (MW+HW)'(cr_mag[i][HW-1:0]);
      crh4_q[i] <= (MW+HW)'(cr_mag[i]) * (MW+HW)'(cr_mag[i][MW-1:HW]);
      nl4_q[i]  <= (N+HW)'(l_mag[i]) * (N+HW)'(d_mag[HW-1:0]);
      nh4_q[i]  <= (N+HW)'(l_mag[i]) * (N+HW)'(d_mag[MW-1:HW]);
    end
    rll4_q <= (RRW+HW)'(rr3_q) * (RRW+HW)'(ll3_q[HW-1:0]);
    rlh4_q <= (RRW+HW)'(rr3_q) * (RRW+HW)'(ll3_q[LLW-1:HW]);
    ll4_q  <= ll3_q;
    tl4_q  <= tl3_q;
    rr4_q  <= rr3_q;
  end

  // Stage 5: partial products combined into full products.
  logic                v5_q;
  logic signed [N-1:0] s5_q [NumAxes];
  logic [NumAxes-1:0]  neg5_q;
  logic [2*MW-1:0]     cr25_q [NumAxes];
  logic [NUMW-1:0]     num5_q [NumAxes];
  logic [RLW-1:0]      rl5_q;
  logic [LLW-1:0]      ll5_q;
  logic [LLW-1:0]      tl5_q;
  logic [RRW-1:0]      rr5_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumAxes; i++) begin
      s5_q[i]   <= s4_q[i];
      cr25_q[i] <= (2*MW)'(crl4_q[i]) + ((2*MW)'(crh4_q[i]) << HW);
      num5_q[i] <= NUMW'(nl4_q[i]) + (NUMW'(nh4_q[i]) << HW);
    end
    neg5_q <= neg4_q;
    rl5_q  <= RLW'(rll4_q) + (RLW'(rlh4_q) << HW);
    ll5_q  <= ll4_q;
    tl5_q  <= tl4_q;
    rr5_q  <= rr4_q;
  end

  // Divider stage arrays; index 0 is loaded by stage 6, index QB feeds the output.
  logic                v_div_q   [QB+1];
  logic signed [N-1:0] s_div_q   [QB+1][NumAxes];
  logic [NumAxes-1:0]  neg_div_q [QB+1];
  logic                lz_div_q  [QB+1];
  logic                hit_div_q [QB+1];
  logic [DW-1:0]       den_div_q [QB+1];
  logic [DW-1:0]       rem_div_q [QB+1][NumAxes];
  logic [QB-1:0]       qx_div_q  [QB+1][NumAxes];

  logic [N2W-1:0] n2_sum;
  logic [XW-1:0]  dividend [NumAxes];

  always_comb begin
    n2_sum = N2W'(cr25_q[0]) + N2W'(cr25_q[1]) + N2W'(cr25_q[2]);
    for (int i = 0; i < NumAxes; i++) begin
      dividend[i] = (XW'(num5_q[i]) << 1) + XW'(ll5_q);
    end
  end

  // Stage 6: hit decision and rounded dividends for the offset divisions.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumAxes; i++) begin
      s_div_q[0][i]   <= s5_q[i];
      rem_div_q[0][i] <= DW'(dividend[i] >> QB);
      qx_div_q[0][i]  <= dividend[i][QB-1:0];
    end
    neg_div_q[0] <= neg5_q;
    lz_div_q[0]  <= (ll5_q == '0);
    hit_div_q[0] <= (ll5_q == '0) ? (LLW'(tl5_q) < LLW'(rr5_q))
                                  : (N2W'(n2_sum) < N2W'(rl5_q));
    den_div_q[0] <= {ll5_q, 1'b0};
  end

  // Restoring divider, one quotient bit per stage shifted in behind the dividend bits.
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DW:0]   trial [NumAxes];
    logic          ge    [NumAxes];

    always_comb begin
      for (int i = 0; i < NumAxes; i++) begin
        trial[i] = {rem_div_q[j][i], qx_div_q[j][i][QB-1]};
        ge[i]    = trial[i] >= {1'b0, den_div_q[j]};
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < NumAxes; i++) begin
        s_div_q[j+1][i]   <= s_div_q[j][i];
        rem_div_q[j+1][i] <= ge[i] ? DW'(trial[i] - {1'b0, den_div_q[j]}) : DW'(trial[i]);
        qx_div_q[j+1][i]  <= {qx_div_q[j][i][QB-2:0], ge[i]};
      end
      neg_div_q[j+1] <= neg_div_q[j];
      lz_div_q[j+1]  <= lz_div_q[j];
      hit_div_q[j+1] <= hit_div_q[j];
      den_div_q[j+1] <= den_div_q[j];
    end
  end

  // Start plus signed offset, clamped to the coordinate range, except for a zero-length line.
  logic signed [SW-1:0] offs [NumAxes];
  logic signed [SW-1:0] psum [NumAxes];
  logic signed [N-1:0]  near_d [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      offs[i] = neg_div_q[QB][i] ? -SW'(qx_div_q[QB][i]) : SW'(qx_div_q[QB][i]);
      psum[i] = SW'(s_div_q[QB][i]) + offs[i];
      priority if (lz_div_q[QB]) begin
        near_d[i] = s_div_q[QB][i];
      end else if (psum[i] > SatHi) begin
        near_d[i] = N'(SatHi);
      end else if (psum[i] < SatLo) begin
        near_d[i] = N'(SatLo);
      end else begin
        near_d[i] = N'(psum[i]);
      end
    end
  end

  // Output register.
  logic                done_q;
  logic                hit_q;
  logic signed [N-1:0] near_q [NumAxes];

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_div_q[QB];
    near_q <= near_d;
  end

  // Valid bits travel beside the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
      for (int j = 0; j <= QB; j++) begin
        v_div_q[j] <= 1'b0;
      end
    end else begin
      v1_q       <= start_i;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      v5_q       <= v4_q;
      v_div_q[0] <= v5_q;
      for (int j = 0; j < QB; j++) begin
        v_div_q[j+1] <= v_div_q[j];
      end
      done_q <= v_div_q[QB];
    end
  end

  assign done_o   = done_q;
  assign hit_o    = hit_q;
  assign near_x_o = near_q[0];
  assign near_y_o = near_q[1];
  assign near_z_o = near_q[2];

endmodule
